// File: rtl/linear_waypoint_interpolator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the interpolator.
// ----------------------------------------------------------------------------
`ifndef LINEAR_WAYPOINT_INTERPOLATOR_CORE_ASSERT_SVH
`define LINEAR_WAYPOINT_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LWI_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define LWI_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define LWI_ASSERT_IMP(label, clk, rst, a, c)
`define LWI_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/lwi_pkg.sv
// ----------------------------------------------------------------------------
// lwi_pkg
// Types and constants shared by the interpolator modules.
// ----------------------------------------------------------------------------
package lwi_pkg;
  localparam int MaxSteps   = 63;
  localparam int CoordWidth = 20;
  localparam int FracBits   = 16;
  localparam int SpuWidth   = 12;
  localparam logic [SpuWidth-1:0] SpuReset = 12'd500;
  localparam int AddrWidth  = 1;
  localparam logic [AddrWidth-1:0] RegStepsPerUnit = 1'b0;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SCALE, BK_SQUARE, BK_SQRT, BK_DIV, BK_EMIT, BK_LAST
  } bk_state_t;
endpackage

// File: rtl/lwi_if.sv
// ----------------------------------------------------------------------------
// lwi_if
// Valid/ready channel carrying an x/y point and one flag bit.
// ----------------------------------------------------------------------------
interface lwi_if #(
  parameter int CW = lwi_pkg::CoordWidth
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] x;
  logic [CW-1:0] y;
  logic          flag;
  modport source (output valid, x, y, flag, input ready);
  modport sink (input valid, x, y, flag, output ready);
endinterface

// File: rtl/lwi_front.sv
// ----------------------------------------------------------------------------
// lwi_front
// Accepts waypoints, tracks previous point, pushes segment words into a queue.
// ----------------------------------------------------------------------------
module lwi_front #(
  parameter int CW = lwi_pkg::CoordWidth
) (
  input  logic          clk,
  input  logic          rst,
  lwi_if.sink           in_ch,
  output logic          q_push,
  input  logic          q_full,
  output logic [4*CW:0] q_word
);
  logic [CW-1:0] prev_x, prev_y;
  logic          have_prev;
  logic          acc;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign q_push      = acc;
  // word: {seg, prev_x, prev_y, x, y}; seg set when a segment is drawn
  assign q_word = {(!in_ch.flag && have_prev), prev_x, prev_y, in_ch.x, in_ch.y};

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else if (acc) begin
      have_prev <= 1'b1;
      prev_x    <= in_ch.x;
      prev_y    <= in_ch.y;
    end
  end
endmodule

// File: rtl/lwi_queue.sv
// ----------------------------------------------------------------------------
// lwi_queue
// Two-entry register queue between front and back.
// ----------------------------------------------------------------------------
module lwi_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;

  assign full     = cnt == 2'd2;
  assign nonempty = cnt != 2'd0;
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/lwi_back.sv
// ----------------------------------------------------------------------------
// lwi_back
// Finds the step count by a bitwise root search, divides deltas serially,
// emits points.
// ----------------------------------------------------------------------------
module lwi_back #(
  parameter int CW = lwi_pkg::CoordWidth,
  parameter int MS = lwi_pkg::MaxSteps
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lwi_pkg::SpuWidth-1:0] spu,
  input  logic                         q_valid,
  input  logic [4*CW:0]                q_word,
  output logic                         q_pop,
  lwi_if.source                        out_ch
);
  localparam int NW  = $clog2(MS + 1);
  localparam int DW  = CW + 1;                 // delta width
  localparam int KW  = lwi_pkg::SpuWidth;
  localparam int AKW = DW + KW;                // |delta| * k
  localparam int LW  = NW + lwi_pkg::FracBits; // |delta| * k below saturation
  localparam int PW  = 2 * LW + 1;             // sum of squares
  localparam int CNW = $clog2(DW + 1);

  lwi_pkg::bk_state_t st, st_next;
  logic                 seg;
  logic [CW-1:0]        px, py, wx, wy, cx, cy, nxx, nxy;
  logic signed [DW-1:0] dx, dy, incx, incy;
  logic [DW-1:0]        ax, ay, rx, ry, qx, qy;
  logic [DW:0]          remx, remy, difx, dify, bestw;
  logic [AKW-1:0]       kx, ky, klim;
  logic [2*LW-1:0]      sqx, sqy;
  logic [PW-1:0]        psum, tcmp;
  logic [NW-1:0]        best, probe, trial, best_upd, idx;
  logic [2*NW-1:0]      tsq;
  logic [CNW-1:0]       cnt;
  logic                 sat, take, out_busy, last_go;

  assign seg  = q_word[4*CW];
  assign ax   = dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
  assign ay   = dy[DW-1] ? $unsigned(-dy) : $unsigned(dy);

  // either axis alone past MS/k units saturates the count
  assign klim = AKW'(MS) << lwi_pkg::FracBits;
  assign sat  = (kx >= klim) || (ky >= klim);
  assign sqx  = {{LW{1'b0}}, kx[LW-1:0]} * {{LW{1'b0}}, kx[LW-1:0]};
  assign sqy  = {{LW{1'b0}}, ky[LW-1:0]} * {{LW{1'b0}}, ky[LW-1:0]};

  // root search: keep trial bit when (trial * 2^16)^2 <= (S * k^2)
  assign trial    = best | probe;
  assign tsq      = {{NW{1'b0}}, trial} * {{NW{1'b0}}, trial};
  assign tcmp     = {1'b0, tsq, {(2*lwi_pkg::FracBits){1'b0}}};
  assign take     = (trial <= NW'(MS)) && (tcmp <= psum);
  assign best_upd = take ? trial : best;

  // restoring divide step on magnitudes
  assign bestw = {{(DW+1-NW){1'b0}}, best};
  assign remx  = {rx, qx[DW-1]};
  assign remy  = {ry, qy[DW-1]};
  assign difx  = remx - bestw;
  assign dify  = remy - bestw;

  assign nxx      = cx + incx[CW-1:0];
  assign nxy      = cy + incy[CW-1:0];
  assign out_busy = out_ch.valid && !out_ch.ready;
  assign last_go  = (st == lwi_pkg::BK_LAST) && !out_busy;
  assign q_pop    = last_go;

  always_comb begin
    st_next = st;
    case (st)
      lwi_pkg::BK_IDLE: begin
        if (q_valid) st_next = seg ? lwi_pkg::BK_SCALE : lwi_pkg::BK_LAST;
      end
      lwi_pkg::BK_SCALE: st_next = lwi_pkg::BK_SQUARE;
      lwi_pkg::BK_SQUARE: st_next = sat ? lwi_pkg::BK_DIV : lwi_pkg::BK_SQRT;
      lwi_pkg::BK_SQRT: begin
        if (probe == NW'(1))
          st_next = (best_upd == '0) ? lwi_pkg::BK_LAST : lwi_pkg::BK_DIV;
      end
      lwi_pkg::BK_DIV: begin
        if (cnt == CNW'(DW)) st_next = lwi_pkg::BK_EMIT;
      end
      lwi_pkg::BK_EMIT: begin
        if (!out_busy && idx == best) st_next = lwi_pkg::BK_LAST;
      end
      lwi_pkg::BK_LAST: begin
        if (!out_busy) st_next = lwi_pkg::BK_IDLE;
      end
      default: st_next = lwi_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= lwi_pkg::BK_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if ((st == lwi_pkg::BK_EMIT || st == lwi_pkg::BK_LAST) && !out_busy) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      lwi_pkg::BK_IDLE: begin
        best <= '0;
        if (q_valid) begin
          px <= q_word[4*CW-1:3*CW];
          py <= q_word[3*CW-1:2*CW];
          wx <= q_word[2*CW-1:CW];
          wy <= q_word[CW-1:0];
          dx <= {q_word[2*CW-1], q_word[2*CW-1:CW]} - {q_word[4*CW-1], q_word[4*CW-1:3*CW]};
          dy <= {q_word[CW-1], q_word[CW-1:0]} - {q_word[3*CW-1], q_word[3*CW-1:2*CW]};
        end
      end
      lwi_pkg::BK_SCALE: begin
        kx <= {{KW{1'b0}}, ax} * {{DW{1'b0}}, spu};
        ky <= {{KW{1'b0}}, ay} * {{DW{1'b0}}, spu};
      end
      lwi_pkg::BK_SQUARE: begin
        psum  <= {1'b0, sqx} + {1'b0, sqy};
        if (sat) best <= NW'(MS);
        probe <= NW'(1) << (NW - 1);
        qx <= ax; qy <= ay; rx <= '0; ry <= '0; cnt <= '0;
      end
      lwi_pkg::BK_SQRT: begin
        best  <= best_upd;
        probe <= probe >> 1;
      end
      lwi_pkg::BK_DIV: begin
        if (cnt != CNW'(DW)) begin
          // one quotient bit per cycle
          if (remx >= bestw) begin
            rx <= difx[DW-1:0];
            qx <= {qx[DW-2:0], 1'b1};
          end else begin
            rx <= remx[DW-1:0];
            qx <= {qx[DW-2:0], 1'b0};
          end
          if (remy >= bestw) begin
            ry <= dify[DW-1:0];
            qy <= {qy[DW-2:0], 1'b1};
          end else begin
            ry <= remy[DW-1:0];
            qy <= {qy[DW-2:0], 1'b0};
          end
          cnt <= cnt + CNW'(1);
        end else begin
          incx <= dx[DW-1] ? -$signed(qx) : $signed(qx);
          incy <= dy[DW-1] ? -$signed(qy) : $signed(qy);
          cx <= px; cy <= py; idx <= NW'(1);
        end
      end
      lwi_pkg::BK_EMIT: begin
        if (!out_busy) begin
          out_ch.x    <= nxx;
          out_ch.y    <= nxy;
          out_ch.flag <= 1'b0;
          cx  <= nxx;
          cy  <= nxy;
          idx <= idx + NW'(1);
        end
      end
      lwi_pkg::BK_LAST: begin
        if (!out_busy) begin
          out_ch.x <= wx; out_ch.y <= wy; out_ch.flag <= 1'b1;
        end
      end
      default: ;
    endcase
  end

`include "linear_waypoint_interpolator_core_assert.svh"
  `LWI_ASSERT_IMP(a_pop_only_last, clk, rst, q_pop, st == lwi_pkg::BK_LAST)
  `LWI_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, q_valid)
  `LWI_ASSERT_IMP(a_best_range, clk, rst, st == lwi_pkg::BK_EMIT, best <= NW'(MS))
  `LWI_ASSERT_NXT(a_last_flag, clk, rst, last_go, out_ch.valid && out_ch.flag)
  `LWI_ASSERT_NXT(a_hold_word, clk, rst, out_busy, out_ch.valid && $stable(out_ch.x))
endmodule

// File: rtl/linear_waypoint_interpolator_core.sv
// ----------------------------------------------------------------------------
// linear_waypoint_interpolator_core
// Linear interpolation between 2D fixed-point waypoints.
// ----------------------------------------------------------------------------
// A waypoint word in gives 1 to MAX_STEPS+1 point words out, the waypoint
// itself always last with its flag set. A path start goes straight to the
// waypoint word. A segment loads and scales the deltas, squares them, runs a
// bitwise step-count search (skipped when the count saturates) and a serial
// division, then emits one point per cycle while the receiver does not hold
// off, and the waypoint last. A zero count skips the division. The front
// keeps the previous point; the small queue holds up to two waypoints, the
// one the back is working on included.
module linear_waypoint_interpolator_core #(
  parameter int COORD_WIDTH = lwi_pkg::CoordWidth,
  parameter int MAX_STEPS   = lwi_pkg::MaxSteps
) (
  input  logic                          clk,
  input  logic                          rst,
  lwi_if.sink                           waypoint,
  lwi_if.source                         point,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lwi_pkg::AddrWidth+1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  logic [lwi_pkg::SpuWidth-1:0] steps_per_unit;
  logic                         q_push, q_full, q_pop, q_nonempty;
  logic [4*COORD_WIDTH:0]       q_in, q_out;

  // config register: steps_per_unit at byte address 0
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) steps_per_unit <= lwi_pkg::SpuReset;
    else if (psel && penable && pwrite &&
             paddr == {lwi_pkg::RegStepsPerUnit, 2'b00})
      steps_per_unit <= pwdata[lwi_pkg::SpuWidth-1:0];
  end
  assign prdata = (paddr == {lwi_pkg::RegStepsPerUnit, 2'b00}) ?
                  {{(32-lwi_pkg::SpuWidth){1'b0}}, steps_per_unit} : 32'd0;

  // front: classify waypoint, attach previous point
  lwi_front #(.CW(COORD_WIDTH)) u_front (
    .clk, .rst, .in_ch(waypoint), .q_push, .q_full, .q_word(q_in)
  );

  // two-word decoupling queue
  lwi_queue #(.W(4*COORD_WIDTH+1)) u_queue (
    .clk, .rst, .push(q_push), .wdata(q_in), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .rdata(q_out)
  );

  // back: count, divide, emit
  lwi_back #(.CW(COORD_WIDTH), .MS(MAX_STEPS)) u_back (
    .clk, .rst, .spu(steps_per_unit), .q_valid(q_nonempty), .q_word(q_out),
    .q_pop, .out_ch(point)
  );
endmodule

// File: tb/linear_waypoint_interpolator_core_tb.sv
// ----------------------------------------------------------------------------
// linear_waypoint_interpolator_core_tb
// Drives waypoint words and register writes into the interpolator, predicts
// every point word from its own model of the segment arithmetic, and checks
// each accepted point word in order under random idling and long stalls.
// ----------------------------------------------------------------------------
module linear_waypoint_interpolator_core_tb;
  localparam int CW = lwi_pkg::CoordWidth;
  localparam longint FRAC_ONE = 64'd65536;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          flag;
  } word_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [lwi_pkg::AddrWidth+1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lwi_if #(.CW(CW)) wp_ch ();
  lwi_if #(.CW(CW)) pt_ch ();

  linear_waypoint_interpolator_core u_top (
    .clk(clk), .rst(rst),
    .waypoint(wp_ch.sink), .point(pt_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: density register and last waypoint.
  longint density;
  longint last_x, last_y;
  bit     have_last;

  word_t waypoint_q[$];   // words waiting for the driver
  word_t point_q[$];      // expected point words, oldest first
  int    errors;
  int    cycles;
  int    send_idle_pct;   // sender idle chance
  int    recv_stall_pct;  // receiver stall chance
  int    hold_cycles;     // long receiver hold-off, counted down below
  bit    sending;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sx(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void add_expect(word_t p);
    point_q.insert(point_q.size(), p);
  endfunction

  function automatic void add_waypoint(word_t w);
    waypoint_q.insert(waypoint_q.size(), w);
  endfunction

  // Largest n with (n*2^16)^2 <= S*k^2, saturated to MaxSteps.
  function automatic longint segment_steps(longint dx, longint dy, longint k);
    longint ax, ay, sk, need, best;
    ax = absv(dx);
    ay = absv(dy);
    best = 0;
    if (k == 0) return 0;
    if (ax * k >= lwi_pkg::MaxSteps * FRAC_ONE || ay * k >= lwi_pkg::MaxSteps * FRAC_ONE)
      return lwi_pkg::MaxSteps;
    sk = (ax * ax + ay * ay) * k;
    for (longint n = 1; n <= lwi_pkg::MaxSteps; n++) begin
      need = (n * n * FRAC_ONE * FRAC_ONE + k - 1) / k;
      if (sk >= need) best = n;
    end
    return best;
  endfunction

  // Queue the point words one waypoint produces.
  task automatic predict_points(word_t w);
    longint x, y, n, ix, iy;
    word_t p;
    x = sx(w.x);
    y = sx(w.y);
    if (!w.flag && have_last) begin
      n = segment_steps(x - last_x, y - last_y, density);
      if (n > 0) begin
        // SV division truncates toward zero, as the block does
        ix = (x - last_x) / n;
        iy = (y - last_y) / n;
        for (longint i = 1; i <= n; i++) begin
          p.x = CW'(last_x + i * ix);
          p.y = CW'(last_y + i * iy);
          p.flag = 1'b0;
          add_expect(p);
        end
      end
    end
    p.x = w.x;
    p.y = w.y;
    p.flag = 1'b1;
    add_expect(p);
    last_x = x;
    last_y = y;
    have_last = 1'b1;
  endtask

  task automatic report(string what, word_t got, word_t want);
    errors++;
    $display("point word %s: got x=%0h y=%0h last=%0b, want x=%0h y=%0h last=%0b",
             what, got.x, got.y, got.flag, want.x, want.y, want.flag);
  endtask

  // Driver: offer the next queued waypoint; prediction at acceptance.
  always @(posedge clk) begin
    if (rst) begin
      wp_ch.valid <= 1'b0;
    end else begin
      if (wp_ch.valid && wp_ch.ready) begin
        predict_points(word_t'{x: wp_ch.x, y: wp_ch.y, flag: wp_ch.flag});
        void'(waypoint_q.pop_front());
      end
      // Decide next offer from the queue as it stands after the pop above.
      if (wp_ch.valid && !wp_ch.ready) begin
        // hold the offer
      end else if (sending && waypoint_q.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        wp_ch.valid <= 1'b1;
        wp_ch.x     <= waypoint_q[0].x;
        wp_ch.y     <= waypoint_q[0].y;
        wp_ch.flag  <= waypoint_q[0].flag;
      end else begin
        wp_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with a long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      pt_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pt_ch.ready <= 1'b0;
    end else begin
      pt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor
  always @(posedge clk) begin
    word_t got, want;
    if (!rst && pt_ch.valid && pt_ch.ready) begin
      got = word_t'{x: pt_ch.x, y: pt_ch.y, flag: pt_ch.flag};
      if (point_q.size() == 0) begin
        report("unexpected", got, got);
      end else begin
        want = point_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.flag !== want.flag)
          report("wrong", got, want);
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("linear_waypoint_interpolator_core: mismatch");
      $finish;
    end
  end

  // APB register write: setup then access.
  task automatic write_density(int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lwi_pkg::RegStepsPerUnit, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    density = value & 12'hFFF;
  endtask

  // Wait until the queue is drained and nothing is owed, then let the
  // block settle (waypoints still in flight finish their last word).
  task automatic drain();
    while (waypoint_q.size() > 0 || wp_ch.valid) @(posedge clk);
    while (point_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    return CW'($urandom);
  endfunction

  // Waypoint near the last queued one so counts span the whole range.
  task automatic queue_path(int len, int spread);
    word_t w;
    longint bx, by;
    bx = sx(rand_coord()) / 2;
    by = sx(rand_coord()) / 2;
    for (int i = 0; i < len; i++) begin
      bx = bx + $signed($urandom_range(2 * spread)) - spread;
      by = by + $signed($urandom_range(2 * spread)) - spread;
      if (bx > 524287) bx = 524287;
      if (bx < -524288) bx = -524288;
      if (by > 524287) by = 524287;
      if (by < -524288) by = -524288;
      w.x = CW'(bx);
      w.y = CW'(by);
      w.flag = (i == 0);
      add_waypoint(w);
    end
  endtask

  task automatic queue_word(longint x, longint y, bit f);
    add_waypoint(word_t'{x: CW'(x), y: CW'(y), flag: f});
  endtask

  initial begin
    int spreads[4];
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    wp_ch.valid = 1'b0; wp_ch.x = '0; wp_ch.y = '0; wp_ch.flag = 1'b0;
    pt_ch.ready = 1'b0;
    errors = 0; cycles = 0; hold_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    sending = 1'b0;
    density = lwi_pkg::SpuReset;
    last_x = 0; last_y = 0; have_last = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sending = 1'b1;

    // Directed: no previous point with flag low, extremes, zero count,
    // saturated segment, negative deltas, restart mid path.
    queue_word(100, -100, 0);
    queue_word(100, -100, 0);
    queue_word(101, -99, 0);
    queue_word(524287, 524287, 0);
    queue_word(-524288, -524288, 0);
    queue_word(-524288, 524287, 0);
    queue_word(0, 0, 1);
    queue_word(65536, 0, 0);
    queue_word(65536, 6553, 0);
    queue_word(-65536, -655, 0);
    queue_word(5, 5, 1);
    queue_word(-3, 7, 0);
    drain();

    write_density(1);
    queue_word(0, 0, 1);
    queue_word(65535, 0, 0);
    queue_word(131072, 0, 0);
    queue_word(131072, 524287, 0);
    queue_word(-524288, -524288, 0);
    drain();

    write_density(4095);
    queue_word(0, 0, 1);
    queue_word(15, 16, 0);
    queue_word(31, 33, 0);
    queue_word(-524288, 0, 0);
    queue_word(-524288, 1, 0);
    drain();

    // Random phases: idling mix and density per phase.
    spreads = '{40, 600, 6000, 200000};
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      case (ph)
        0: write_density(500);
        3: write_density(4095);
        5: write_density(1);
        default: write_density($urandom_range(4095, 1));
      endcase
      for (int p = 0; p < 3; p++)
        queue_path($urandom_range(7, 4), spreads[$urandom_range(3)]);
      if ($urandom_range(1)) queue_word(rand_coord(), rand_coord(), 1'($urandom_range(1)));
      if (ph == 2) hold_cycles = 600;  // block fills and backs up input
      drain();
    end

    // Sender pauses until everything owed has arrived, then a last burst.
    send_idle_pct = 0; recv_stall_pct = 30;
    queue_path(6, 3000);
    drain();

    if (errors == 0) begin
      $display("linear_waypoint_interpolator_core: match");
    end else begin
      $display("linear_waypoint_interpolator_core: mismatch");
    end
    $finish;
  end
endmodule

// File: linear_waypoint_interpolator_core.f
+incdir+rtl
rtl/lwi_pkg.sv
rtl/lwi_if.sv
rtl/lwi_front.sv
rtl/lwi_queue.sv
rtl/lwi_back.sv
rtl/linear_waypoint_interpolator_core.sv
tb/linear_waypoint_interpolator_core_tb.sv
